// File: rtl/core/usedst_pkg.sv
// usedst_pkg: widths, constants and item types of the us eastern dst offset pipeline
// no dependencies; used by every module in rtl/core

package usedst_pkg;

	localparam int unsigned TIME_W   = 33;
	localparam int unsigned OFFSET_W = 16;
	localparam int unsigned DAYS_W   = 17;
	localparam int unsigned DOE_W    = 18;
	localparam int unsigned YOE_W    = 9;
	localparam int unsigned YEAR_W   = 12;
	localparam int unsigned SECS_W   = 34;

	// seconds to days: (t >> 7) / 675 by reciprocal, exact for 26-bit operands
	localparam logic [26:0] DAY_RECIP = 27'd101806633;

	// civil-from-days constants, day numbers counted from 0000-03-01
	localparam logic [19:0] EPOCH_SHIFT = 20'd719468;
	localparam logic [19:0] ERA4_START  = 20'd584388;
	localparam logic [19:0] ERA5_START  = 20'd730485;
	localparam logic [17:0] DOE_CENT1   = 18'd36524;
	localparam logic [17:0] DOE_CENT2   = 18'd73048;
	localparam logic [17:0] DOE_CENT3   = 18'd109572;

	// (doe >> 2) / 365 and n / 365 by reciprocal
	localparam logic [16:0] RECIP_1460 = 17'd91930;
	localparam logic [18:0] RECIP_365  = 19'd367720;

	localparam logic [8:0] YOE_CENT1 = 9'd100;
	localparam logic [8:0] YOE_CENT2 = 9'd200;
	localparam logic [8:0] YOE_CENT3 = 9'd300;
	localparam logic [8:0] DOY_JAN   = 9'd306;

	localparam logic [YEAR_W-1:0] YEAR_ERA4 = 12'd1600;
	localparam logic [YEAR_W-1:0] YEAR_ERA5 = 12'd2000;

	// x % 7 by reciprocal, exact for 17-bit operands
	localparam logic [17:0] MOD7_RECIP = 18'd149797;

	localparam logic [16:0] SECS_PER_DAY = 17'd86400;
	// 07:00 utc on the march sunday
	localparam logic [SECS_W-1:0] START_SECS = 34'd25200;
	// 06:00 utc on the november sunday, 238 days after the march sunday
	localparam logic [SECS_W-1:0] END_SECS   = 34'd20584800;

	localparam logic signed [OFFSET_W-1:0] OFFSET_DAYLIGHT = -16'sd14400;
	localparam logic signed [OFFSET_W-1:0] OFFSET_STANDARD = -16'sd18000;

	typedef struct packed {
		logic [TIME_W-1:0] t;
		logic              era5;
		logic [DOE_W-1:0]  doe;
	} usedst_doe_t;

	typedef struct packed {
		logic [TIME_W-1:0] t;
		logic [YEAR_W-1:0] year;
	} usedst_year_t;

endpackage

// File: rtl/core/usedst_days.sv
// usedst_days: two stages, unix seconds to era and day of era
// depends on usedst_pkg

module usedst_days (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic [usedst_pkg::TIME_W-1:0]       unix_seconds,
	output logic                                out_valid,
	input  logic                                out_ready,
	output usedst_pkg::usedst_doe_t             out_item
);

	logic                            valid_s1, valid_s2;
	logic                            take_s1, take_s2;
	logic [usedst_pkg::TIME_W-1:0]   t_s1;
	logic [52:0]                     prod_s1;
	usedst_pkg::usedst_doe_t         item_s2;

	logic [usedst_pkg::DAYS_W-1:0]   days;
	logic [19:0]                     z;
	logic                            era5;
	logic [19:0]                     doe_full;

	assign take_s2  = !valid_s2 || out_ready;
	assign take_s1  = !valid_s1 || take_s2;
	assign in_ready = take_s1;

	// stage 1: reciprocal multiply for the day number
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (take_s1) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (take_s1 && in_valid) begin
			t_s1    <= unix_seconds;
			prod_s1 <= 53'(unix_seconds[32:7]) * 53'(usedst_pkg::DAY_RECIP);
		end
	end

	// stage 2: era is 4 or 5 over the whole input range
	always_comb begin
		days     = prod_s1[52:36];
		z        = 20'(days) + usedst_pkg::EPOCH_SHIFT;
		era5     = (z >= usedst_pkg::ERA5_START);
		doe_full = z - (era5 ? usedst_pkg::ERA5_START : usedst_pkg::ERA4_START);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (take_s2) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (take_s2 && valid_s1) begin
			item_s2.t    <= t_s1;
			item_s2.era5 <= era5;
			item_s2.doe  <= doe_full[usedst_pkg::DOE_W-1:0];
		end
	end

	assign out_valid = valid_s2;
	assign out_item  = item_s2;

endmodule

// File: rtl/core/usedst_year.sv
// usedst_year: five stages, era and day of era to utc calendar year
// depends on usedst_pkg

module usedst_year (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  usedst_pkg::usedst_doe_t     in_item,
	output logic                        out_valid,
	input  logic                        out_ready,
	output usedst_pkg::usedst_year_t    out_item
);

	logic valid_s3, valid_s4, valid_s5, valid_s6, valid_s7;
	logic take_s3, take_s4, take_s5, take_s6, take_s7;

	usedst_pkg::usedst_doe_t          item_s3, item_s4, item_s5, item_s6;
	logic [32:0]                      prod_s3;
	logic [1:0]                       cent_s3;
	logic [usedst_pkg::DOE_W-1:0]     n_s4;
	logic [36:0]                      prod_s5;
	logic [usedst_pkg::YOE_W-1:0]     yoe_s6;
	logic [8:0]                       doy_s6;
	usedst_pkg::usedst_year_t         item_s7;

	logic [1:0]                       cent;
	logic [7:0]                       q1460;
	logic [usedst_pkg::DOE_W-1:0]     n;
	logic [usedst_pkg::YOE_W-1:0]     yoe;
	logic [1:0]                       yoe_cent;
	logic [usedst_pkg::DOE_W-1:0]     yoe_days;
	logic [usedst_pkg::DOE_W-1:0]     doy_full;
	logic [usedst_pkg::YEAR_W-1:0]    year;

	assign take_s7  = !valid_s7 || out_ready;
	assign take_s6  = !valid_s6 || take_s7;
	assign take_s5  = !valid_s5 || take_s6;
	assign take_s4  = !valid_s4 || take_s5;
	assign take_s3  = !valid_s3 || take_s4;
	assign in_ready = take_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
			valid_s6 <= 1'b0;
			valid_s7 <= 1'b0;
		end else begin
			if (take_s3) valid_s3 <= in_valid;
			if (take_s4) valid_s4 <= valid_s3;
			if (take_s5) valid_s5 <= valid_s4;
			if (take_s6) valid_s6 <= valid_s5;
			if (take_s7) valid_s7 <= valid_s6;
		end
	end

	// doe / 36524 - doe / 146096
	always_comb begin
		cent = 2'(in_item.doe >= usedst_pkg::DOE_CENT1)
			+ 2'(in_item.doe >= usedst_pkg::DOE_CENT2)
			+ 2'(in_item.doe >= usedst_pkg::DOE_CENT3);
	end

	// stage 3: doe / 1460 by reciprocal
	always_ff @(posedge clk) begin
		if (take_s3 && in_valid) begin
			item_s3 <= in_item;
			prod_s3 <= 33'(in_item.doe[17:2]) * 33'(usedst_pkg::RECIP_1460);
			cent_s3 <= cent;
		end
	end

	// stage 4: leap-corrected day count
	always_comb begin
		q1460 = prod_s3[32:25];
		n     = item_s3.doe - 18'(q1460) + 18'(cent_s3);
	end

	always_ff @(posedge clk) begin
		if (take_s4 && valid_s3) begin
			item_s4 <= item_s3;
			n_s4    <= n;
		end
	end

	// stage 5: year of era by reciprocal
	always_ff @(posedge clk) begin
		if (take_s5 && valid_s4) begin
			item_s5 <= item_s4;
			prod_s5 <= 37'(n_s4) * 37'(usedst_pkg::RECIP_365);
		end
	end

	// stage 6: day of the march-based year
	always_comb begin
		yoe      = prod_s5[35:27];
		yoe_cent = 2'(yoe >= usedst_pkg::YOE_CENT1)
			+ 2'(yoe >= usedst_pkg::YOE_CENT2)
			+ 2'(yoe >= usedst_pkg::YOE_CENT3);
		yoe_days = 18'(yoe) * 18'd365 + 18'(yoe[8:2]) - 18'(yoe_cent);
		doy_full = item_s5.doe - yoe_days;
	end

	always_ff @(posedge clk) begin
		if (take_s6 && valid_s5) begin
			item_s6 <= item_s5;
			yoe_s6  <= yoe;
			doy_s6  <= doy_full[8:0];
		end
	end

	// stage 7: january and february belong to the next civil year
	always_comb begin
		year = 12'(yoe_s6)
			+ (item_s6.era5 ? usedst_pkg::YEAR_ERA5 : usedst_pkg::YEAR_ERA4)
			+ 12'(doy_s6 >= usedst_pkg::DOY_JAN);
	end

	always_ff @(posedge clk) begin
		if (take_s7 && valid_s6) begin
			item_s7.t    <= item_s6.t;
			item_s7.year <= year;
		end
	end

	assign out_valid = valid_s7;
	assign out_item  = item_s7;

endmodule

// File: rtl/core/usedst_window.sv
// usedst_window: five stages, year to the dst window and the final flag
// depends on usedst_pkg

module usedst_window (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  usedst_pkg::usedst_year_t    in_item,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic                        dst
);

	logic valid_s8, valid_s9, valid_s10, valid_s11, valid_s12;
	logic take_s8, take_s9, take_s10, take_s11, take_s12;

	logic [usedst_pkg::TIME_W-1:0]  t_s8, t_s9, t_s10, t_s11;
	logic [usedst_pkg::DAYS_W-1:0]  base_s8;
	logic [usedst_pkg::DAYS_W-1:0]  x_s9;
	logic [34:0]                    prod_s9;
	logic [usedst_pkg::DAYS_W-1:0]  start_day_s10;
	logic [usedst_pkg::SECS_W-1:0]  day_secs_s11;
	logic                           dst_s12;

	logic                           era5;
	logic [usedst_pkg::YEAR_W-1:0]  yoe_full;
	logic [usedst_pkg::YOE_W-1:0]   yoe;
	logic [1:0]                     yoe_cent;
	logic [20:0]                    base_full;
	logic [usedst_pkg::DAYS_W-1:0]  x;
	logic [14:0]                    q7;
	logic [usedst_pkg::DAYS_W-1:0]  rem_full;
	logic [2:0]                     dow;
	logic [3:0]                     first;
	logic [usedst_pkg::SECS_W-1:0]  start_secs;
	logic [usedst_pkg::SECS_W-1:0]  end_secs;
	logic [usedst_pkg::SECS_W-1:0]  t_wide;

	assign take_s12 = !valid_s12 || out_ready;
	assign take_s11 = !valid_s11 || take_s12;
	assign take_s10 = !valid_s10 || take_s11;
	assign take_s9  = !valid_s9  || take_s10;
	assign take_s8  = !valid_s8  || take_s9;
	assign in_ready = take_s8;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s8  <= 1'b0;
			valid_s9  <= 1'b0;
			valid_s10 <= 1'b0;
			valid_s11 <= 1'b0;
			valid_s12 <= 1'b0;
		end else begin
			if (take_s8)  valid_s8  <= in_valid;
			if (take_s9)  valid_s9  <= valid_s8;
			if (take_s10) valid_s10 <= valid_s9;
			if (take_s11) valid_s11 <= valid_s10;
			if (take_s12) valid_s12 <= valid_s11;
		end
	end

	// stage 8: day number of march 1 of the year
	always_comb begin
		era5      = (in_item.year >= usedst_pkg::YEAR_ERA5);
		yoe_full  = in_item.year - (era5 ? usedst_pkg::YEAR_ERA5 : usedst_pkg::YEAR_ERA4);
		yoe       = yoe_full[usedst_pkg::YOE_W-1:0];
		yoe_cent  = 2'(yoe >= usedst_pkg::YOE_CENT1)
			+ 2'(yoe >= usedst_pkg::YOE_CENT2)
			+ 2'(yoe >= usedst_pkg::YOE_CENT3);
		base_full = 21'(era5 ? usedst_pkg::ERA5_START : usedst_pkg::ERA4_START)
			+ 21'(yoe) * 21'd365 + 21'(yoe[8:2]) - 21'(yoe_cent)
			- 21'(usedst_pkg::EPOCH_SHIFT);
	end

	always_ff @(posedge clk) begin
		if (take_s8 && in_valid) begin
			t_s8    <= in_item.t;
			base_s8 <= base_full[usedst_pkg::DAYS_W-1:0];
		end
	end

	// stage 9: weekday reciprocal, day 0 of the count was a thursday
	assign x = base_s8 + 17'd4;

	always_ff @(posedge clk) begin
		if (take_s9 && valid_s8) begin
			t_s9    <= t_s8;
			x_s9    <= x;
			prod_s9 <= 35'(x) * 35'(usedst_pkg::MOD7_RECIP);
		end
	end

	// stage 10: second sunday of march; november 1 shares the weekday of march 1
	always_comb begin
		q7       = prod_s9[34:20];
		rem_full = x_s9 - 17'({q7, 3'b000}) + 17'(q7);
		dow      = rem_full[2:0];
		first    = (dow == 3'd0) ? 4'd1 : (4'd8 - 4'(dow));
	end

	always_ff @(posedge clk) begin
		if (take_s10 && valid_s9) begin
			t_s10         <= t_s9;
			start_day_s10 <= x_s9 + 17'(first) + 17'd2;
		end
	end

	// stage 11: midnight of the march sunday in seconds
	always_ff @(posedge clk) begin
		if (take_s11 && valid_s10) begin
			t_s11        <= t_s10;
			day_secs_s11 <= 34'(start_day_s10) * 34'(usedst_pkg::SECS_PER_DAY);
		end
	end

	// stage 12: half-open window test
	always_comb begin
		start_secs = day_secs_s11 + usedst_pkg::START_SECS;
		end_secs   = day_secs_s11 + usedst_pkg::END_SECS;
		t_wide     = 34'(t_s11);
	end

	always_ff @(posedge clk) begin
		if (take_s12 && valid_s11) begin
			dst_s12 <= (t_wide >= start_secs) && (t_wide < end_secs);
		end
	end

	assign out_valid = valid_s12;
	assign dst       = dst_s12;

endmodule

// File: rtl/core/us_eastern_dst_offset_top.sv
// us_eastern_dst_offset_top: unix seconds to us eastern dst flag and utc offset
// depends on usedst_pkg, usedst_days, usedst_year, usedst_window
//
// channel | direction | handshake            | payload
// --------+-----------+----------------------+-------------------------------------
// in      | input     | in_valid / in_ready  | unix_seconds[32:0]
// out     | output    | out_valid / out_ready| dst_active, utc_offset_seconds[15:0]
//
// twelve register stages; one item enters per cycle while in_ready is high; its result
// passes through stages 1 to 12 in order and is held on the output until out_ready takes it
// each stage holds one item and takes a new one whenever it is empty or its
// successor moves, so bubbles close up and a full pipeline holds twelve items
// a stall on out_ready backs up stage by stage; nothing is dropped or repeated
// arst_n clears the stage valid bits and the in-flight count; payload registers load on demand

module us_eastern_dst_offset_top (
	input  logic                                           clk,
	input  logic                                           arst_n,
	input  logic                                           in_valid,
	output logic                                           in_ready,
	input  logic [usedst_pkg::TIME_W-1:0]                  unix_seconds,
	output logic                                           out_valid,
	input  logic                                           out_ready,
	output logic                                           dst_active,
	output logic signed [usedst_pkg::OFFSET_W-1:0]         utc_offset_seconds
);

	localparam int unsigned PIPE_DEPTH = 12;

	// days -> year handoff
	logic                       days_valid;
	logic                       days_ready;
	usedst_pkg::usedst_doe_t    days_item;

	// year -> window handoff
	logic                       yr_valid;
	logic                       yr_ready;
	usedst_pkg::usedst_year_t   yr_item;

	logic                       dst;

	// items accepted but not yet delivered, for checking only
	logic [3:0]                 inflight_q;
	logic                       in_fire;
	logic                       out_fire;

	// stages 1-2: seconds to day number, then era and day of era
	usedst_days u_days (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.unix_seconds (unix_seconds),
		.out_valid    (days_valid),
		.out_ready    (days_ready),
		.out_item     (days_item)
	);

	// stages 3-7: civil-from-days down to the utc year
	usedst_year u_year (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (days_valid),
		.in_ready  (days_ready),
		.in_item   (days_item),
		.out_valid (yr_valid),
		.out_ready (yr_ready),
		.out_item  (yr_item)
	);

	// stages 8-12: march and november sundays and the window compare
	usedst_window u_window (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (yr_valid),
		.in_ready  (yr_ready),
		.in_item   (yr_item),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.dst       (dst)
	);

	// offset follows the registered flag directly
	assign dst_active         = dst;
	assign utc_offset_seconds = dst ? usedst_pkg::OFFSET_DAYLIGHT
		: usedst_pkg::OFFSET_STANDARD;

	assign in_fire  = in_valid && in_ready;
	assign out_fire = out_valid && out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inflight_q <= 4'd0;
		end else begin
			case ({in_fire, out_fire})
				2'b10: begin
					inflight_q <= inflight_q + 4'd1;
				end
				2'b01: begin
					inflight_q <= inflight_q - 4'd1;
				end
				default: begin
					inflight_q <= inflight_q;
				end
			endcase
		end
	end

	// the pipeline never holds more items than it has stages
	a_inflight_bound: assert property (@(posedge clk) disable iff (!arst_n)
		inflight_q <= 4'(PIPE_DEPTH))
		else $error("more items in flight than pipeline stages");

	// a result is only shown for an item that was accepted
	a_no_phantom: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (inflight_q != 4'd0))
		else $error("result shown with no item in flight");

	// a year item blocked at the window stays put until taken
	a_year_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(yr_valid && !yr_ready) |=> (yr_valid && $stable(yr_item)))
		else $error("year item lost or changed while stalled");

endmodule

// File: dv/us_eastern_dst_offset_top_test.sv
// us_eastern_dst_offset_top_test: self-checking bench for the us eastern dst offset pipeline
// drives unix times through valid/ready, predicts flag and offset in-bench, checks every result
// depends on usedst_pkg and us_eastern_dst_offset_top

module us_eastern_dst_offset_top_test;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned T_W   = usedst_pkg::TIME_W;
	localparam int unsigned OFS_W = usedst_pkg::OFFSET_W;

	// largest 33-bit time, lands in march 2242
	localparam logic [63:0] MAX_TIME  = 64'h1_FFFF_FFFF;
	localparam logic [63:0] DAY_SECS  = 64'd86400;
	localparam logic [63:0] HOUR_SECS = 64'd3600;
	localparam logic signed [OFS_W-1:0] EDT_OFFSET = OFS_W'(-4 * 3600);
	localparam logic signed [OFS_W-1:0] EST_OFFSET = OFS_W'(-5 * 3600);

	localparam int RANDOM_ITEMS = 1300;
	localparam int CYCLE_LIMIT  = 400000;
	localparam int DRAIN_CYCLES = 30;
	localparam int HOLD_CYCLES  = 250;
	localparam int REPORT_MAX   = 10;

	typedef struct {
		logic [T_W-1:0]          t;
		logic                    dst;
		logic signed [OFS_W-1:0] offset;
	} dst_verdict_t;

	logic                    clk = 1'b0;
	logic                    arst_n = 1'b0;
	logic                    in_valid = 1'b0;
	logic                    in_ready;
	logic [T_W-1:0]          unix_seconds = '0;
	logic                    out_valid;
	logic                    out_ready = 1'b0;
	logic                    dst_active;
	logic signed [OFS_W-1:0] utc_offset_seconds;

	us_eastern_dst_offset_top dut (
		.clk                (clk),
		.arst_n             (arst_n),
		.in_valid           (in_valid),
		.in_ready           (in_ready),
		.unix_seconds       (unix_seconds),
		.out_valid          (out_valid),
		.out_ready          (out_ready),
		.dst_active         (dst_active),
		.utc_offset_seconds (utc_offset_seconds)
	);

	// times waiting to be offered, and verdicts of accepted times in arrival order
	logic [T_W-1:0] pending_times[$];
	dst_verdict_t   pending_verdicts[$];

	int cycle_count    = 0;
	int items_accepted = 0;
	int results_seen   = 0;
	int errors         = 0;
	int n_directed     = 0;
	int n_edge         = 0;
	int n_newyear      = 0;
	int n_uniform      = 0;

	// idle pattern state of both sides
	int send_gap    = 0;
	int send_burst  = 0;
	int recv_stall  = 0;
	int recv_calm   = 0;
	int recv_hold   = 0;
	int holds_given = 0;
	int recv_taken  = 0;

	// ------------------------------------------------------------------
	// calendar predictor
	// ------------------------------------------------------------------

	// days since 1970-01-01 of a date in a march-based year (month 3..14)
	function automatic logic [63:0] day_index(input logic [63:0] yr, input logic [63:0] mon,
			input logic [63:0] dom);
		logic [63:0] era, yoe, doy, doe;
		era = yr / 400;
		yoe = yr - era * 400;
		doy = (153 * (mon - 3) + 2) / 5 + dom - 1;
		doe = yoe * 365 + yoe / 4 - yoe / 100 + doy;
		return era * 146097 + doe - 719468;
	endfunction

	// utc calendar year of a day count since the epoch
	function automatic logic [63:0] year_of_day(input logic [63:0] days);
		logic [63:0] z, era, doe, yoe, doy, mp, yr;
		z   = days + 719468;
		era = z / 146097;
		doe = z - era * 146097;
		yoe = (doe - doe / 1460 + doe / 36524 - doe / 146096) / 365;
		doy = doe - (365 * yoe + yoe / 4 - yoe / 100);
		mp  = (5 * doy + 2) / 153;
		yr  = yoe + era * 400;
		// march-based months 10 and 11 are january and february of the next year
		return (mp >= 10) ? yr + 1 : yr;
	endfunction

	// day of month of the first sunday
	function automatic logic [63:0] opening_sunday(input logic [63:0] yr, input logic [63:0] mon);
		logic [63:0] dow;
		dow = (day_index(yr, mon, 1) + 4) % 7;
		return 1 + (7 - dow) % 7;
	endfunction

	// daylight time runs from 07:00 utc on the second march sunday
	// up to, not including, 06:00 utc on the first november sunday
	function automatic logic [63:0] dst_start(input logic [63:0] yr);
		return day_index(yr, 3, opening_sunday(yr, 3) + 7) * DAY_SECS + 7 * HOUR_SECS;
	endfunction

	function automatic logic [63:0] dst_end(input logic [63:0] yr);
		return day_index(yr, 11, opening_sunday(yr, 11)) * DAY_SECS + 6 * HOUR_SECS;
	endfunction

	function automatic logic [63:0] new_year(input logic [63:0] yr);
		// january 1 is day 306 of the march-based year before
		return day_index(yr - 1, 13, 1) * DAY_SECS;
	endfunction

	function automatic dst_verdict_t eastern_verdict(input logic [T_W-1:0] t);
		dst_verdict_t v;
		logic [63:0] secs, yr;
		secs     = 64'(t);
		yr       = year_of_day(secs / DAY_SECS);
		v.t      = t;
		v.dst    = (secs >= dst_start(yr)) && (secs < dst_end(yr));
		v.offset = v.dst ? EDT_OFFSET : EST_OFFSET;
		return v;
	endfunction

	// ------------------------------------------------------------------
	// idle patterns
	// ------------------------------------------------------------------

	// sender gap after an item: runs without gaps, mostly short gaps, a few long ones
	function automatic int next_send_gap();
		int r;
		if (send_burst > 0) begin
			send_burst--;
			return 0;
		end
		r = $urandom_range(0, 99);
		if (r < 6) begin
			send_burst = $urandom_range(20, 80);
			return 0;
		end
		if (r < 55)
			return 0;
		if (r < 93)
			return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	function automatic int next_recv_stall();
		int r;
		r = $urandom_range(0, 99);
		if (r < 70)
			return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	// ------------------------------------------------------------------
	// stimulus helpers
	// ------------------------------------------------------------------

	function automatic logic [T_W-1:0] any_time();
		return {1'($urandom_range(0, 1)), 32'($urandom())};
	endfunction

	// a time near a given instant, half the time within two seconds, else within two hours
	function automatic logic [T_W-1:0] near(input logic [63:0] instant);
		longint cand;
		if ($urandom_range(0, 1) == 0)
			cand = longint'(instant) + $urandom_range(0, 4) - 2;
		else
			cand = longint'(instant) + $urandom_range(0, 14400) - 7200;
		if (cand < 0 || cand > longint'(MAX_TIME))
			return any_time();
		return T_W'(cand);
	endfunction

	task automatic add_directed(input logic [63:0] t);
		// instants past the 33-bit range are skipped, the last year is cut short
		if (t <= MAX_TIME) begin
			pending_times.insert(pending_times.size(), T_W'(t));
			n_directed++;
		end
	endtask

	// ------------------------------------------------------------------
	// clock and watchdog
	// ------------------------------------------------------------------

	initial begin
		forever #6 clk = ~clk;
	end

	always @(posedge clk)
		cycle_count <= cycle_count + 1;

	initial begin : watchdog
		while (cycle_count < CYCLE_LIMIT)
			@(posedge clk);
		$display("timeout after %0d cycles, %0d results outstanding", cycle_count,
			pending_verdicts.size());
		$display("simulation failed");
		$finish;
	end

	// ------------------------------------------------------------------
	// sender: offers queued times, records the verdict of each accepted item
	// ------------------------------------------------------------------

	always @(posedge clk or negedge arst_n) begin : sender
		logic           nxt_valid;
		logic [T_W-1:0] nxt_time;
		if (!arst_n) begin
			in_valid     <= 1'b0;
			unix_seconds <= '0;
			send_gap     = 0;
		end else begin
			nxt_valid = in_valid;
			nxt_time  = unix_seconds;
			if (in_valid && in_ready) begin
				pending_verdicts.insert(pending_verdicts.size(), eastern_verdict(unix_seconds));
				items_accepted++;
				nxt_valid = 1'b0;
			end
			// a held item stays put until taken; otherwise load the next one after its gap
			if (!nxt_valid) begin
				if (send_gap > 0) begin
					send_gap--;
				end else if (pending_times.size() > 0) begin
					nxt_valid = 1'b1;
					nxt_time  = pending_times.pop_front();
					send_gap  = next_send_gap();
				end
			end
			in_valid     <= nxt_valid;
			unix_seconds <= nxt_time;
		end
	end

	// ------------------------------------------------------------------
	// receiver: random stalls, calm stretches, and two long hold-offs that
	// back the pipeline up until in_ready drops while the sender keeps offering
	// ------------------------------------------------------------------

	always @(posedge clk or negedge arst_n) begin : receiver
		logic rdy;
		if (!arst_n) begin
			out_ready  <= 1'b0;
			recv_stall = 0;
			recv_calm  = 0;
			recv_hold  = 0;
		end else begin
			if (out_valid && out_ready)
				recv_taken++;
			if ((holds_given == 0 && recv_taken >= 300) ||
					(holds_given == 1 && recv_taken >= 900)) begin
				recv_hold = HOLD_CYCLES;
				holds_given++;
			end
			if (recv_hold > 0) begin
				recv_hold--;
				rdy = 1'b0;
			end else if (recv_stall > 0) begin
				recv_stall--;
				rdy = 1'b0;
			end else begin
				rdy = 1'b1;
				if (recv_calm > 0)
					recv_calm--;
				else if ($urandom_range(0, 99) < 3)
					recv_calm = $urandom_range(40, 150);
				else if ($urandom_range(0, 99) < 30)
					recv_stall = next_recv_stall();
			end
			out_ready <= rdy;
		end
	end

	// ------------------------------------------------------------------
	// scoreboard: every taken result against the oldest outstanding verdict
	// ------------------------------------------------------------------

	always @(posedge clk) begin : scoreboard
		dst_verdict_t want;
		if (arst_n && out_valid && out_ready) begin
			results_seen++;
			if (pending_verdicts.size() == 0) begin
				errors++;
				if (errors <= REPORT_MAX)
					$display("unexpected result dst=%0b offset=%0d with no item outstanding",
						dst_active, utc_offset_seconds);
			end else begin
				want = pending_verdicts.pop_front();
				if (dst_active !== want.dst || utc_offset_seconds !== want.offset) begin
					errors++;
					if (errors <= REPORT_MAX)
						$display("mismatch t=%0d: expected dst=%0b offset=%0d, got dst=%0b offset=%0d",
							want.t, want.dst, want.offset, dst_active, utc_offset_seconds);
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// stimulus and end of run
	// ------------------------------------------------------------------

	initial begin : stimulus
		logic [63:0] yr;
		int          r;

		// range ends and the 32-bit rollover points
		add_directed(64'd0);
		add_directed(64'd1);
		add_directed(MAX_TIME);
		add_directed(64'h7FFF_FFFF);
		add_directed(64'h8000_0000);
		add_directed(64'hFFFF_FFFF);
		add_directed(64'h1_0000_0000);
		// interval edges: start is daylight time, end is standard time
		add_directed(dst_start(1970) - 1);
		add_directed(dst_start(1970));
		add_directed(dst_end(1970) - 1);
		add_directed(dst_end(1970));
		// leap year on an era boundary, a non-leap century, a recent leap year
		add_directed(dst_start(2000));
		add_directed(dst_end(2000) - 1);
		add_directed(dst_start(2100) - 1);
		add_directed(dst_end(2100));
		add_directed(dst_start(2024));
		add_directed(dst_end(2024));
		// the last whole season and the cut-short final year
		add_directed(dst_end(2241) - 1);
		add_directed(dst_end(2241));
		add_directed(dst_start(2242) - 1);
		add_directed(dst_start(2242));
		// new year crossings
		add_directed(new_year(2001) - 1);
		add_directed(new_year(2001));
		add_directed(new_year(2242));

		// random part, most of it around the instants where the answer flips
		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			r  = $urandom_range(0, 99);
			yr = $urandom_range(1970, 2242);
			if (r < 55) begin
				pending_times.insert(pending_times.size(),
					near($urandom_range(0, 1) ? dst_start(yr) : dst_end(yr)));
				n_edge++;
			end else if (r < 65) begin
				if (yr == 1970)
					yr = 1971;
				pending_times.insert(pending_times.size(), near(new_year(yr)));
				n_newyear++;
			end else begin
				pending_times.insert(pending_times.size(), any_time());
				n_uniform++;
			end
		end

		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (pending_times.size() > 0 || in_valid)
			@(posedge clk);
		while (pending_verdicts.size() > 0)
			@(posedge clk);
		// keep watching the output to catch any stray result
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (pending_verdicts.size() > 0) begin
			errors += pending_verdicts.size();
			$display("%0d expected results never arrived", pending_verdicts.size());
		end

		$display("run: %0d items (%0d directed, %0d near dst edges, %0d near new year, %0d uniform)",
			items_accepted, n_directed, n_edge, n_newyear, n_uniform);
		$display("run: %0d results checked, %0d long receiver hold-offs, %0d errors",
			results_seen, holds_given, errors);
		if (errors == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

endmodule
